>>> hdl/sle_pkg.sv
// ----------------------------------------------------------------------------
// sle_pkg
// Types and codes shared by the list engine's controller, datapath and top.
// ----------------------------------------------------------------------------
package sle_pkg;

    typedef enum logic [1:0] {
        CMD_INSERT = 2'd0,
        CMD_DELETE = 2'd1,
        CMD_LOCATE = 2'd2,
        CMD_GET    = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_RANGE = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        PTR_ZERO   = 2'd0,
        PTR_POS_M1 = 2'd1,
        PTR_CNT_M1 = 2'd2
    } t_ptr_sel;

    typedef struct packed {
        t_cmd               cmd;
        logic        [7:0]  position;
        logic signed [31:0] value;
    } t_in_item;

    typedef struct packed {
        t_status            status;
        logic signed [31:0] data;
        logic        [7:0]  found_at;
        logic        [7:0]  length;
    } t_out_item;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic     load;
        logic     ptr_load;
        t_ptr_sel ptr_sel;
        logic     ptr_inc;
        logic     ptr_dec;
        logic     rd_en;
        logic     wr_move;
        logic     wr_value;
        logic     cmp_en;
        logic     cap_data;
        logic     cnt_inc;
        logic     cnt_dec;
        logic     set_status;
        t_status  status;
        logic     out_load;
    } t_ctl;

    // Status from the datapath to the controller.
    typedef struct packed {
        t_cmd cmd;
        logic ins_err;
        logic full;
        logic acc_err;
        logic ins_no_move;
        logic del_no_move;
        logic cnt_zero;
        logic at_pos_m1;
        logic at_cnt_m1;
        logic hit;
    } t_sts;

endpackage

>>> hdl/sle_dp.sv
// ----------------------------------------------------------------------------
// sle_dp
// List store, length count, walking pointer and result registers.
// ----------------------------------------------------------------------------
module sle_dp #(
    parameter int CAPACITY = 128
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  sle_pkg::t_ctl     i_ctl,
    input  sle_pkg::t_in_item i_item,
    output sle_pkg::t_sts     o_sts,
    output sle_pkg::t_out_item o_result
);
    import sle_pkg::*;

    localparam int AW   = $clog2(CAPACITY);
    localparam int CW   = $clog2(CAPACITY + 1);
    localparam int CMPW = (CW > 8) ? CW : 8;
    localparam int FW   = (AW + 1 > 8) ? AW + 1 : 8;

    logic signed [31:0] r_mem [CAPACITY];
    logic signed [31:0] r_rd_data;
    logic [CW-1:0]      r_count;
    t_in_item           r_item;
    logic [AW-1:0]      r_ptr;
    logic               r_pend;
    logic [AW-1:0]      r_pend_addr;
    t_status            r_status;
    logic signed [31:0] r_data;
    logic [7:0]         r_found;
    t_out_item          r_out;

    logic [CMPW-1:0]    pos_w;
    logic [CMPW-1:0]    cnt_w;
    logic [CMPW-1:0]    pos_dec;
    logic [CMPW-1:0]    cnt_dec;
    logic [CMPW:0]      cnt_inc;
    logic [AW-1:0]      pos_m1;
    logic [AW-1:0]      cnt_m1;
    logic [FW-1:0]      found_sum;
    logic               wr_en;
    logic [AW-1:0]      wr_addr;
    logic signed [31:0] wr_data;

    always_comb begin
        pos_w     = CMPW'(r_item.position);
        cnt_w     = CMPW'(r_count);
        pos_dec   = pos_w - CMPW'(1);
        cnt_dec   = cnt_w - CMPW'(1);
        cnt_inc   = {1'b0, cnt_w} + (CMPW + 1)'(1);
        pos_m1    = pos_dec[AW-1:0];
        cnt_m1    = cnt_dec[AW-1:0];
        found_sum = FW'(r_pend_addr) + FW'(1);

        o_sts.cmd         = r_item.cmd;
        o_sts.ins_err     = (pos_w == '0) || ({1'b0, pos_w} > cnt_inc);
        o_sts.full        = (cnt_w == CMPW'(CAPACITY));
        o_sts.acc_err     = (pos_w == '0) || (pos_w > cnt_w);
        o_sts.ins_no_move = ({1'b0, pos_w} == cnt_inc);
        o_sts.del_no_move = (pos_w == cnt_w);
        o_sts.cnt_zero    = (cnt_w == '0);
        o_sts.at_pos_m1   = (r_ptr == pos_m1);
        o_sts.at_cnt_m1   = (r_ptr == cnt_m1);
        o_sts.hit         = r_pend && (r_rd_data == r_item.value);

        // A move writes the entry fetched in the previous cycle one place up
        // for an insert and one place down for a delete.
        wr_en   = i_ctl.wr_value || (i_ctl.wr_move && r_pend);
        wr_data = r_rd_data;
        if (i_ctl.wr_value) begin
            wr_addr = pos_m1;
            wr_data = r_item.value;
        end else if (r_item.cmd == CMD_INSERT) begin
            wr_addr = r_pend_addr + AW'(1);
        end else begin
            wr_addr = r_pend_addr - AW'(1);
        end

        o_result = r_out;
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.rd_en) begin
            r_rd_data <= r_mem[r_ptr];
        end
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_pend  <= 1'b0;
        end else begin
            r_pend <= i_ctl.rd_en;
            if (i_ctl.cnt_inc) begin
                r_count <= r_count + CW'(1);
            end else if (i_ctl.cnt_dec) begin
                r_count <= r_count - CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_item   <= i_item;
            r_status <= ST_OK;
            r_data   <= '0;
            r_found  <= '0;
        end
        if (i_ctl.ptr_load) begin
            case (i_ctl.ptr_sel)
                PTR_POS_M1: r_ptr <= pos_m1;
                PTR_CNT_M1: r_ptr <= cnt_m1;
                default:    r_ptr <= '0;
            endcase
        end else if (i_ctl.ptr_inc) begin
            r_ptr <= r_ptr + AW'(1);
        end else if (i_ctl.ptr_dec) begin
            r_ptr <= r_ptr - AW'(1);
        end
        if (i_ctl.rd_en) begin
            r_pend_addr <= r_ptr;
        end
        if (i_ctl.set_status) begin
            r_status <= i_ctl.status;
        end
        if (i_ctl.cap_data) begin
            r_data <= r_rd_data;
        end
        if (i_ctl.cmp_en && o_sts.hit) begin
            r_found <= found_sum[7:0];
        end
        if (i_ctl.out_load) begin
            r_out.status   <= r_status;
            r_out.data     <= r_data;
            r_out.found_at <= r_found;
            r_out.length   <= cnt_w[7:0];
        end
    end

endmodule

>>> hdl/sle_ctrl.sv
// ----------------------------------------------------------------------------
// sle_ctrl
// Sequencer for the list engine: checks each command, walks the store and
// hands the result to the output register.
// ----------------------------------------------------------------------------
module sle_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    output logic          o_valid,
    input  logic          i_ready,
    input  sle_pkg::t_sts i_sts,
    output sle_pkg::t_ctl o_ctl
);
    import sle_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CHECK,
        S_SHIFT_UP,
        S_SHIFT_DN,
        S_DRAIN,
        S_INS_WRITE,
        S_FETCH,
        S_CAPTURE,
        S_SCAN,
        S_SCAN_END,
        S_DONE
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;

    always_comb begin
        o_ctl       = '0;
        n_state     = r_state;
        n_out_valid = r_out_valid;
        if (r_out_valid && i_ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_ctl.load = 1'b1;
                    n_state    = S_CHECK;
                end
            end
            S_CHECK: begin
                case (i_sts.cmd)
                    CMD_INSERT: begin
                        if (i_sts.ins_err) begin
                            o_ctl.set_status = 1'b1;
                            o_ctl.status     = ST_RANGE;
                            n_state          = S_DONE;
                        end else if (i_sts.full) begin
                            o_ctl.set_status = 1'b1;
                            o_ctl.status     = ST_FULL;
                            n_state          = S_DONE;
                        end else if (i_sts.ins_no_move) begin
                            n_state = S_INS_WRITE;
                        end else begin
                            o_ctl.ptr_load = 1'b1;
                            o_ctl.ptr_sel  = PTR_CNT_M1;
                            n_state        = S_SHIFT_UP;
                        end
                    end
                    CMD_DELETE, CMD_GET: begin
                        if (i_sts.acc_err) begin
                            o_ctl.set_status = 1'b1;
                            o_ctl.status     = ST_RANGE;
                            n_state          = S_DONE;
                        end else begin
                            o_ctl.ptr_load = 1'b1;
                            o_ctl.ptr_sel  = PTR_POS_M1;
                            n_state        = S_FETCH;
                        end
                    end
                    CMD_LOCATE: begin
                        if (i_sts.cnt_zero) begin
                            n_state = S_DONE;
                        end else begin
                            o_ctl.ptr_load = 1'b1;
                            o_ctl.ptr_sel  = PTR_ZERO;
                            n_state        = S_SCAN;
                        end
                    end
                    default: n_state = S_DONE;
                endcase
            end
            S_SHIFT_UP: begin
                // Fetch one entry and store the one fetched in the previous cycle.
                o_ctl.rd_en   = 1'b1;
                o_ctl.wr_move = 1'b1;
                if (i_sts.at_pos_m1) begin
                    n_state = S_DRAIN;
                end else begin
                    o_ctl.ptr_dec = 1'b1;
                end
            end
            S_SHIFT_DN: begin
                o_ctl.rd_en   = 1'b1;
                o_ctl.wr_move = 1'b1;
                if (i_sts.at_cnt_m1) begin
                    n_state = S_DRAIN;
                end else begin
                    o_ctl.ptr_inc = 1'b1;
                end
            end
            S_DRAIN: begin
                o_ctl.wr_move = 1'b1;
                if (i_sts.cmd == CMD_INSERT) begin
                    n_state = S_INS_WRITE;
                end else begin
                    o_ctl.cnt_dec = 1'b1;
                    n_state       = S_DONE;
                end
            end
            S_INS_WRITE: begin
                o_ctl.wr_value = 1'b1;
                o_ctl.cnt_inc  = 1'b1;
                n_state        = S_DONE;
            end
            S_FETCH: begin
                o_ctl.rd_en   = 1'b1;
                o_ctl.ptr_inc = 1'b1;
                n_state       = S_CAPTURE;
            end
            S_CAPTURE: begin
                o_ctl.cap_data = 1'b1;
                if (i_sts.cmd == CMD_GET) begin
                    n_state = S_DONE;
                end else if (i_sts.del_no_move) begin
                    o_ctl.cnt_dec = 1'b1;
                    n_state       = S_DONE;
                end else begin
                    n_state = S_SHIFT_DN;
                end
            end
            S_SCAN: begin
                // The compare works on the entry fetched in the previous cycle.
                o_ctl.rd_en  = 1'b1;
                o_ctl.cmp_en = 1'b1;
                if (i_sts.hit) begin
                    n_state = S_DONE;
                end else if (i_sts.at_cnt_m1) begin
                    n_state = S_SCAN_END;
                end else begin
                    o_ctl.ptr_inc = 1'b1;
                end
            end
            S_SCAN_END: begin
                o_ctl.cmp_en = 1'b1;
                n_state      = S_DONE;
            end
            S_DONE: begin
                if (!r_out_valid || i_ready) begin
                    o_ctl.out_load = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_ready = (r_state == S_IDLE);
    assign o_valid = r_out_valid;

endmodule

>>> hdl/sequential_list_engine.sv
// ----------------------------------------------------------------------------
// sequential_list_engine
// Ordered list of signed 32-bit values with insert, delete, locate and get.
//
//   Channel  Direction  Handshake            Payload
//   input    in         i_valid / o_ready    i_data  (cmd, position, value)
//   result   out        o_valid / i_ready    o_data  (status, data, found_at, length)
//
// One command is worked at a time; the store has one read and one write
// port, so one entry is moved or compared per cycle. A result waiting in
// the output register does not block acceptance of the next command, but
// that command waits in its final state until the register is free. The
// synchronous reset clears the length to an empty list.
// ----------------------------------------------------------------------------
module sequential_list_engine #(
    parameter int CAPACITY = 128
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  sle_pkg::t_in_item  i_data,
    output logic               o_valid,
    input  logic               i_ready,
    output sle_pkg::t_out_item o_data
);
    import sle_pkg::*;

    t_ctl ctl;
    t_sts sts;

    sle_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .i_sts   (sts),
        .o_ctl   (ctl)
    );

    sle_dp #(
        .CAPACITY (CAPACITY)
    ) u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (ctl),
        .i_item   (i_data),
        .o_sts    (sts),
        .o_result (o_data)
    );

    // The list never grows past its capacity nor shrinks below empty.
    a_no_grow_when_full: assert property (
        @(posedge i_clk) disable iff (!i_rst_n) ctl.cnt_inc |-> !sts.full
    ) else $error("length incremented on a full list");

    a_no_shrink_when_empty: assert property (
        @(posedge i_clk) disable iff (!i_rst_n) ctl.cnt_dec |-> !sts.cnt_zero
    ) else $error("length decremented on an empty list");

    a_single_write: assert property (
        @(posedge i_clk) disable iff (!i_rst_n) !(ctl.wr_value && ctl.wr_move)
    ) else $error("two store writes requested in one cycle");

    a_busy_after_accept: assert property (
        @(posedge i_clk) disable iff (!i_rst_n) (i_valid && o_ready) |=> !o_ready
    ) else $error("new transaction accepted while one is in progress");

endmodule
